// File: hw/rtl/gw_pkg.sv
// Shared constants, types and helpers for the grid-to-world coordinate mapper.
// No dependencies; every other file of the block uses this package.
package gw_pkg;

  localparam int DIM_BITS  = 16;             // grid dimension limit is 2^DIM_BITS
  localparam int LIM_W     = DIM_BITS + 1;   // width of a limited count
  localparam int CNT_W     = 17;             // count register width
  localparam int COORD_W   = 48;             // Q24.24 coordinate width
  localparam int IDX_W     = 32;             // linear index width
  localparam int DIM_W     = 16;             // explicit row/col input width
  localparam int PROD_W    = COORD_W + DIM_BITS + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIV_STEPS = 4;              // quotient bits per divider stage
  localparam int DIV_STG   = IDX_W / DIV_STEPS;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = 2;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ROW  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_COL  = 2'd2;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT  = 3'd0,
    REG_COL_COUNT  = 3'd1,
    REG_COEF_X_ROW = 3'd2,
    REG_COEF_X_COL = 3'd3,
    REG_OFFSET_X   = 3'd4,
    REG_COEF_Y_ROW = 3'd5,
    REG_COEF_Y_COL = 3'd6,
    REG_OFFSET_Y   = 3'd7
  } cfg_reg_t;

  // One beat moving through the divider: quo starts as the index and
  // ends as the quotient, rem ends as the remainder.
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [IDX_W-1:0] quo;
    logic [LIM_W-1:0] rem;
    logic [DIM_W-1:0] row_in;
    logic [DIM_W-1:0] col_in;
  } div_item_t;

  function automatic logic [LIM_W-1:0] limit_count(logic [CNT_W-1:0] n);
    logic [39:0] w;
    logic [39:0] cap;
    w   = 40'(n);
    cap = 40'(1) << DIM_BITS;
    if (w > cap) return LIM_W'(cap);
    return LIM_W'(w);
  endfunction

endpackage

// File: hw/rtl/gw_if.sv
// Valid/ready stream interfaces for request and response beats.
// Depends on gw_pkg for field widths.
interface gw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [gw_pkg::IDX_W-1:0]  linear_index;
  logic [gw_pkg::DIM_W-1:0]  row_in;
  logic [gw_pkg::DIM_W-1:0]  col_in;
  modport source (output valid, kind, linear_index, row_in, col_in, input ready);
  modport sink   (input valid, kind, linear_index, row_in, col_in, output ready);
endinterface

interface gw_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [gw_pkg::COORD_W-1:0] world_x;
  logic signed [gw_pkg::COORD_W-1:0] world_y;
  logic [gw_pkg::ERR_W-1:0]         error_code;
  modport source (output valid, world_x, world_y, error_code, input ready);
  modport sink   (input valid, world_x, world_y, error_code, output ready);
endinterface

// File: hw/rtl/grid_index_to_world_coordinate_core.sv
// Top level of the grid-to-world coordinate mapper.
// Depends on gw_pkg, gw_if, gw_divider and gw_affine.
//
//  channel | dir | beat contents
//  req     | in  | kind, linear_index, row_in, col_in
//  rsp     | out | world_x, world_y, error_code
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle while rsp is not stalled; stages: input register, 8 divider
// stages of 4 quotient bits each, range check, multiply, add/saturate.
// Reset clears all valid bits and loads the config defaults.
// A stall on rsp freezes the whole pipeline in place; req.ready drops
// only while a response is held.
module grid_index_to_world_coordinate_core (
  input  logic                         clk,
  input  logic                         rst,
  gw_in_if.sink                        req,
  gw_out_if.source                     rsp,
  input  logic                         cfg_we,
  input  logic [gw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gw_pkg::CFG_W-1:0]     cfg_data
);

  // configuration
  logic [gw_pkg::CNT_W-1:0]   row_count, col_count;
  logic [gw_pkg::COORD_W-1:0] coef_x_row, coef_x_col, offset_x;
  logic [gw_pkg::COORD_W-1:0] coef_y_row, coef_y_col, offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= gw_pkg::CNT_W'(1);
      col_count  <= gw_pkg::CNT_W'(1);
      coef_x_row <= gw_pkg::COORD_W'(16777216);
      coef_x_col <= '0;
      offset_x   <= '0;
      coef_y_row <= '0;
      coef_y_col <= gw_pkg::COORD_W'(16777216);
      offset_y   <= '0;
    end else if (cfg_we) begin
      unique case (gw_pkg::cfg_reg_t'(cfg_index))
        gw_pkg::REG_ROW_COUNT:  row_count  <= cfg_data[gw_pkg::CNT_W-1:0];
        gw_pkg::REG_COL_COUNT:  col_count  <= cfg_data[gw_pkg::CNT_W-1:0];
        gw_pkg::REG_COEF_X_ROW: coef_x_row <= cfg_data[gw_pkg::COORD_W-1:0];
        gw_pkg::REG_COEF_X_COL: coef_x_col <= cfg_data[gw_pkg::COORD_W-1:0];
        gw_pkg::REG_OFFSET_X:   offset_x   <= cfg_data[gw_pkg::COORD_W-1:0];
        gw_pkg::REG_COEF_Y_ROW: coef_y_row <= cfg_data[gw_pkg::COORD_W-1:0];
        gw_pkg::REG_COEF_Y_COL: coef_y_col <= cfg_data[gw_pkg::COORD_W-1:0];
        gw_pkg::REG_OFFSET_Y:   offset_y   <= cfg_data[gw_pkg::COORD_W-1:0];
      endcase
    end
  end

  // counts capped at 2^DIM_BITS; the user must move config only while idle (not enforced)
  logic [gw_pkg::LIM_W-1:0] nrows, ncols;
  assign nrows = gw_pkg::limit_count(row_count);
  assign ncols = gw_pkg::limit_count(col_count);

  // global advance: everything moves unless a held response blocks
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input register
  gw_pkg::div_item_t in_q, div_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q <= '0;
    end else if (en) begin
      in_q.valid  <= req.valid;
      in_q.kind   <= req.kind;
      in_q.quo    <= req.linear_index;
      in_q.rem    <= '0;
      in_q.row_in <= req.row_in;
      in_q.col_in <= req.col_in;
    end
  end

  gw_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .ncols (ncols),
    .d_in  (in_q),
    .d_out (div_out)
  );

  // pick row/col and range check
  logic [gw_pkg::IDX_W-1:0]    row_w, col_w;
  logic [gw_pkg::ERR_W-1:0]    err_next;
  logic                        v_sel, v_mul, v_out;
  logic [gw_pkg::ERR_W-1:0]    err_sel, err_mul, err_out;
  logic [gw_pkg::DIM_BITS-1:0] row_sel, col_sel;

  always_comb begin
    if (div_out.kind) begin
      row_w = gw_pkg::IDX_W'(div_out.row_in);
      col_w = gw_pkg::IDX_W'(div_out.col_in);
    end else begin
      row_w = div_out.quo;
      col_w = gw_pkg::IDX_W'(div_out.rem);
    end
    if (!div_out.kind && ncols == '0) begin
      // row 0, col = index: column always fails unless no rows at all
      err_next = (nrows == '0) ? gw_pkg::ERR_ROW : gw_pkg::ERR_COL;
    end else if (row_w >= gw_pkg::IDX_W'(nrows)) begin
      err_next = gw_pkg::ERR_ROW;
    end else if (col_w >= gw_pkg::IDX_W'(ncols)) begin
      err_next = gw_pkg::ERR_COL;
    end else begin
      err_next = gw_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sel <= 1'b0;
      v_mul <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v_sel <= div_out.valid;
      v_mul <= v_sel;
      v_out <= v_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_sel <= row_w[gw_pkg::DIM_BITS-1:0];
      col_sel <= col_w[gw_pkg::DIM_BITS-1:0];
      err_sel <= err_next;
      err_mul <= err_sel;
      err_out <= err_mul;
    end
  end

  logic ok_sel;
  assign ok_sel = (err_sel == gw_pkg::ERR_NONE);

  gw_affine u_ax (
    .clk (clk), .en (en), .ok (ok_sel), .row (row_sel), .col (col_sel),
    .coef_row (coef_x_row), .coef_col (coef_x_col), .offset (offset_x),
    .coord (rsp.world_x)
  );

  gw_affine u_ay (
    .clk (clk), .en (en), .ok (ok_sel), .row (row_sel), .col (col_sel),
    .coef_row (coef_y_row), .coef_col (coef_y_col), .offset (offset_y),
    .coord (rsp.world_y)
  );

  assign rsp.valid      = v_out;
  assign rsp.error_code = err_out;

endmodule

// File: hw/rtl/gw_divider.sv
// Pipelined restoring divider: linear index / column count.
// Depends on gw_pkg; DIV_STEPS quotient bits per register stage.
module gw_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [gw_pkg::LIM_W-1:0] ncols,
  input  gw_pkg::div_item_t        d_in,
  output gw_pkg::div_item_t        d_out
);

  gw_pkg::div_item_t pipe [0:gw_pkg::DIV_STG];

  assign pipe[0] = d_in;

  for (genvar k = 0; k < gw_pkg::DIV_STG; k++) begin : g_stg
    gw_pkg::div_item_t       nxt;
    logic [gw_pkg::LIM_W-1:0] sh;
    logic                     ge;

    always_comb begin
      nxt = pipe[k];
      sh  = '0;
      ge  = 1'b0;
      for (int j = 0; j < gw_pkg::DIV_STEPS; j++) begin
        sh      = {nxt.rem[gw_pkg::LIM_W-2:0], nxt.quo[gw_pkg::IDX_W-1]};
        ge      = (sh >= ncols);
        nxt.rem = ge ? (sh - ncols) : sh;
        nxt.quo = {nxt.quo[gw_pkg::IDX_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k+1] <= '0;
      end else if (en) begin
        pipe[k+1] <= nxt;
      end
    end
  end

  assign d_out = pipe[gw_pkg::DIV_STG];

endmodule

// File: hw/rtl/gw_affine.sv
// One axis of the affine map: two products, offset add, saturation, zero when not ok.
// Depends on gw_pkg; two register stages.
module gw_affine (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              ok,
  input  logic [gw_pkg::DIM_BITS-1:0]       row,
  input  logic [gw_pkg::DIM_BITS-1:0]       col,
  input  logic [gw_pkg::COORD_W-1:0]        coef_row,
  input  logic [gw_pkg::COORD_W-1:0]        coef_col,
  input  logic [gw_pkg::COORD_W-1:0]        offset,
  output logic signed [gw_pkg::COORD_W-1:0] coord
);

  logic signed [gw_pkg::PROD_W-1:0]  prod_row;
  logic signed [gw_pkg::PROD_W-1:0]  prod_col;
  logic signed [gw_pkg::COORD_W-1:0] offset_q;
  logic                              ok_q;
  logic signed [gw_pkg::SUM_W-1:0]   sum;
  logic signed [gw_pkg::COORD_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_row <= $signed(coef_row) * $signed({1'b0, row});
      prod_col <= $signed(coef_col) * $signed({1'b0, col});
      offset_q <= $signed(offset);
      ok_q     <= ok;
    end
  end

  always_comb begin
    sum = gw_pkg::SUM_W'(prod_row) + gw_pkg::SUM_W'(prod_col) + gw_pkg::SUM_W'(offset_q);
    // in range when the coordinate sign bit and all bits above it agree
    if ((&sum[gw_pkg::SUM_W-1:gw_pkg::COORD_W-1]) || !(|sum[gw_pkg::SUM_W-1:gw_pkg::COORD_W-1]))
      sat = sum[gw_pkg::COORD_W-1:0];
    else if (sum[gw_pkg::SUM_W-1])
      sat = gw_pkg::COORD_MIN;
    else
      sat = gw_pkg::COORD_MAX;
  end

  always_ff @(posedge clk) begin
    if (en) coord <= ok_q ? sat : '0;
  end

endmodule

// File: hw/rtl/gw_checker.sv
// Port-level checks for the grid-to-world mapper, bound to the top level.
// Depends on gw_pkg.
module gw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [gw_pkg::COORD_W-1:0] world_x,
  input logic signed [gw_pkg::COORD_W-1:0] world_y,
  input logic [gw_pkg::ERR_W-1:0]         error_code
);

  // request side only backs up behind a held response
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("req ready not tied to response stall");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error_code != gw_pkg::ERR_NONE |-> world_x == '0 && world_y == '0)
    else $error("error beat carries nonzero coordinates");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> error_code == gw_pkg::ERR_NONE || error_code == gw_pkg::ERR_ROW ||
                  error_code == gw_pkg::ERR_COL)
    else $error("bad error code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(world_x) && $stable(world_y) &&
                                $stable(error_code))
    else $error("stalled response changed");

endmodule

bind grid_index_to_world_coordinate_core gw_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .world_x    (rsp.world_x),
  .world_y    (rsp.world_y),
  .error_code (rsp.error_code)
);

// File: tb/grid_index_to_world_coordinate_core_tb.sv
// Self-checking testbench for the grid-to-world coordinate mapper.
// Depends on gw_pkg, gw_if and grid_index_to_world_coordinate_core.
`timescale 1ns / 100ps
module grid_index_to_world_coordinate_core_tb;

  typedef struct packed {
    logic                     kind;
    logic [gw_pkg::IDX_W-1:0] linear_index;
    logic [gw_pkg::DIM_W-1:0] row_in;
    logic [gw_pkg::DIM_W-1:0] col_in;
  } cell_req_t;

  typedef struct packed {
    logic [gw_pkg::COORD_W-1:0] world_x;
    logic [gw_pkg::COORD_W-1:0] world_y;
    logic [gw_pkg::ERR_W-1:0]   error_code;
  } coord_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [gw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gw_pkg::CFG_W-1:0] cfg_data;

  gw_in_if  req();
  gw_out_if rsp();

  grid_index_to_world_coordinate_core u_top (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Local copy of the register file for prediction.
  logic [gw_pkg::CNT_W-1:0]   m_rows, m_cols;
  logic [gw_pkg::COORD_W-1:0] m_coef [8];

  cell_req_t pending_cells[$];
  coord_t    expected_coords[$];
  int        err_count;
  int        send_idle_pct, recv_idle_pct;
  int        stall_cycles;
  bit        hold_sender;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [gw_pkg::COORD_W-1:0] got,
                        input logic [gw_pkg::COORD_W-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Exact affine sum in 128 bits, then clamp to the signed 48-bit range.
  function automatic logic [gw_pkg::COORD_W-1:0] map_axis(logic [gw_pkg::COORD_W-1:0] a,
      logic [gw_pkg::COORD_W-1:0] b, logic [gw_pkg::COORD_W-1:0] c, longint unsigned r,
      longint unsigned k);
    logic signed [127:0] acc;
    acc = 128'(signed'(a)) * $signed({1'b0, 64'(r)})
        + 128'(signed'(b)) * $signed({1'b0, 64'(k)})
        + 128'(signed'(c));
    if (acc > 128'sh7FFF_FFFF_FFFF) return gw_pkg::COORD_MAX;
    if (acc < -128'sh8000_0000_0000) return gw_pkg::COORD_MIN;
    return acc[gw_pkg::COORD_W-1:0];
  endfunction

  function automatic coord_t predict_coord(cell_req_t c);
    longint unsigned nr, nc, r, k;
    coord_t o;
    nr = (m_rows > 17'h10000) ? 64'h10000 : 64'(m_rows);
    nc = (m_cols > 17'h10000) ? 64'h10000 : 64'(m_cols);
    if (!c.kind) begin
      if (nc == 0) begin
        r = 0;
        k = 64'(c.linear_index);
      end else begin
        r = 64'(c.linear_index) / nc;
        k = 64'(c.linear_index) % nc;
      end
    end else begin
      r = 64'(c.row_in);
      k = 64'(c.col_in);
    end
    o = '0;
    if (r >= nr) o.error_code = gw_pkg::ERR_ROW;
    else if (k >= nc) o.error_code = gw_pkg::ERR_COL;
    else begin
      o.error_code = gw_pkg::ERR_NONE;
      o.world_x = map_axis(m_coef[gw_pkg::REG_COEF_X_ROW], m_coef[gw_pkg::REG_COEF_X_COL],
                           m_coef[gw_pkg::REG_OFFSET_X], r, k);
      o.world_y = map_axis(m_coef[gw_pkg::REG_COEF_Y_ROW], m_coef[gw_pkg::REG_COEF_Y_COL],
                           m_coef[gw_pkg::REG_OFFSET_Y], r, k);
    end
    return o;
  endfunction

  // Driver: one beat per queue entry, random gaps, NBA at the edge.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_coords.push_back(predict_coord(pending_cells.pop_front()));
      end
      if (!req.valid || req.ready) begin
        if (pending_cells.size() > 0 &&
            !hold_sender && $urandom_range(99) >= send_idle_pct) begin
          req.valid        <= 1'b1;
          req.kind         <= pending_cells[0].kind;
          req.linear_index <= pending_cells[0].linear_index;
          req.row_in       <= pending_cells[0].row_in;
          req.col_in       <= pending_cells[0].col_in;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each response beat with the oldest expectation.
  always @(posedge clk) begin
    coord_t want;
    if (rst) begin
      rsp.ready    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_coords.size() == 0) begin
          report("unexpected beat", rsp.world_x, '0);
        end else begin
          want = expected_coords.pop_front();
          if (rsp.world_x !== want.world_x) report("world_x", rsp.world_x, want.world_x);
          if (rsp.world_y !== want.world_y) report("world_y", rsp.world_y, want.world_y);
          if (rsp.error_code !== want.error_code)
            report("error_code", 48'(rsp.error_code), 48'(want.error_code));
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      // Watchdog: cycles with no beat accepted on either side.
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drop a cell into the send queue.
  task automatic push_cell(bit kind, logic [31:0] li, logic [15:0] r, logic [15:0] c);
    cell_req_t e;
    e.kind = kind;
    e.linear_index = li;
    e.row_in = r;
    e.col_in = c;
    pending_cells.push_back(e);
  endtask

  // Wait until every queued cell is sent and answered, then pipeline drains.
  task automatic drain();
    while (pending_cells.size() != 0 || expected_coords.size() != 0 || req.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One write; the enable is dropped again before the next write.
  task automatic write_reg(gw_pkg::cfg_reg_t idx, logic [gw_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gw_pkg::REG_ROW_COUNT) m_rows = val[gw_pkg::CNT_W-1:0];
    else if (idx == gw_pkg::REG_COL_COUNT) m_cols = val[gw_pkg::CNT_W-1:0];
    else m_coef[idx] = val[gw_pkg::COORD_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Mostly in-grid cells, the rest raw random values that are mostly out of range.
  task automatic random_cells(int n);
    int sel;
    longint unsigned nr, nc;
    nr = (m_rows > 17'h10000) ? 64'h10000 : 64'(m_rows);
    nc = (m_cols > 17'h10000) ? 64'h10000 : 64'(m_cols);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel < 4 && nr > 0 && nc > 0 && nr * nc <= 64'hFFFF_FFFF)
        push_cell(1'b0, 32'($urandom_range(32'(nr * nc - 1))), 16'($urandom),
                  16'($urandom));
      else if (sel < 7 && nr > 0 && nc > 0)
        push_cell(1'b1, $urandom, 16'($urandom_range(32'(nr - 1))),
                  16'($urandom_range(32'(nc - 1))));
      else
        push_cell(1'($urandom), $urandom, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = gw_pkg::REG_ROW_COUNT;
    cfg_data = '0;
    req.valid = 1'b0;
    req.kind = 1'b0;
    req.linear_index = '0;
    req.row_in = '0;
    req.col_in = '0;
    rsp.ready = 1'b0;
    err_count = 0;
    hold_sender = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 86;
    m_rows = 1;
    m_cols = 1;
    m_coef[gw_pkg::REG_COEF_X_ROW] = 48'd16777216;
    m_coef[gw_pkg::REG_COEF_X_COL] = '0;
    m_coef[gw_pkg::REG_OFFSET_X]   = '0;
    m_coef[gw_pkg::REG_COEF_Y_ROW] = '0;
    m_coef[gw_pkg::REG_COEF_Y_COL] = 48'd16777216;
    m_coef[gw_pkg::REG_OFFSET_Y]   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: 1x1 grid, only cell 0 is valid.
    push_cell(1'b0, 32'd0, 16'd0, 16'd0);
    push_cell(1'b0, 32'd1, 16'd0, 16'd0);
    push_cell(1'b1, 32'd0, 16'd0, 16'd1);
    push_cell(1'b1, 32'd0, 16'hFFFF, 16'hFFFF);
    drain();

    // Full-size grid with extreme coefficients: overflow both ways.
    write_reg(gw_pkg::REG_ROW_COUNT, 48'h1FFFF);     // clamps to 2^16
    write_reg(gw_pkg::REG_COL_COUNT, 48'h10000);
    write_reg(gw_pkg::REG_COEF_X_ROW, 48'h7FFF_FFFF_FFFF);
    write_reg(gw_pkg::REG_COEF_X_COL, 48'h8000_0000_0000);
    write_reg(gw_pkg::REG_OFFSET_X, 48'h7FFF_FFFF_FFFF);
    write_reg(gw_pkg::REG_COEF_Y_ROW, 48'h8000_0000_0000);
    write_reg(gw_pkg::REG_COEF_Y_COL, 48'hFFFF_FFFF_FFFF);
    write_reg(gw_pkg::REG_OFFSET_Y, 48'h8000_0000_0000);
    push_cell(1'b0, 32'hFFFF_FFFF, 16'd0, 16'd0);
    push_cell(1'b0, 32'h0001_0000, 16'd0, 16'd0);
    push_cell(1'b1, 32'd0, 16'hFFFF, 16'd0);
    push_cell(1'b1, 32'd0, 16'd0, 16'hFFFF);
    push_cell(1'b1, 32'd0, 16'd1, 16'd1);
    push_cell(1'b1, 32'd0, 16'd0, 16'd0);
    drain();

    // Zero counts: column check, then row check.
    write_reg(gw_pkg::REG_COL_COUNT, 48'd0);
    push_cell(1'b0, 32'd5, 16'd0, 16'd0);
    push_cell(1'b1, 32'd0, 16'd3, 16'd0);
    drain();
    write_reg(gw_pkg::REG_ROW_COUNT, 48'd0);
    push_cell(1'b0, 32'd5, 16'd0, 16'd0);
    push_cell(1'b1, 32'd0, 16'd0, 16'd0);
    drain();

    // Odd-sized grid: index past the end, row-first order.
    write_reg(gw_pkg::REG_ROW_COUNT, 48'd7);
    write_reg(gw_pkg::REG_COL_COUNT, 48'd13);
    push_cell(1'b0, 32'd90, 16'd0, 16'd0);
    push_cell(1'b0, 32'd91, 16'd0, 16'd0);
    push_cell(1'b1, 32'd0, 16'd7, 16'd13);
    push_cell(1'b1, 32'd0, 16'd6, 16'd13);
    drain();

    // Random phases; idle ratios rotate between them.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 86; recv_idle_pct = 35; end
      if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_reg(gw_pkg::REG_ROW_COUNT,
                (ph == 1) ? 48'h10000 : 48'($urandom_range(1, 300)));
      write_reg(gw_pkg::REG_COL_COUNT,
                (ph == 3) ? 48'h1FFFF : 48'($urandom_range(1, 300)));
      for (int r = gw_pkg::REG_COEF_X_ROW; r <= gw_pkg::REG_OFFSET_Y; r++)
        write_reg(gw_pkg::cfg_reg_t'(r), (ph == 5) ? 48'h8000_0000_0000 :
                  rand48() >>> $urandom_range(20));
      random_cells(130);
      // Hold the sender off until everything in flight has come back.
      while (pending_cells.size() > 65) @(posedge clk);
      hold_sender = 1'b1;
      while (expected_coords.size() != 0 || req.valid) @(posedge clk);
      hold_sender = 1'b0;
      random_cells(130);
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: grid_index_to_world_coordinate_core.f
hw/rtl/gw_pkg.sv
hw/rtl/gw_if.sv
hw/rtl/gw_divider.sv
hw/rtl/gw_affine.sv
hw/rtl/grid_index_to_world_coordinate_core.sv
hw/rtl/gw_checker.sv
tb/grid_index_to_world_coordinate_core_tb.sv
